// File: src/q2e_pkg.sv
// Shared widths, types, constants and helper functions of the quaternion to
// Euler angle converter. Depends on nothing; every other file imports it.
package q2e_pkg;

    // Fixed configuration of the datapath
    localparam int QUAT_WIDTH    = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int SQRT_STAGES   = 32;

    // Derived widths
    localparam int PROD_W    = 2 * QUAT_WIDTH;
    localparam int PROD_FRAC = 2 * (QUAT_WIDTH - 1);
    localparam int Q30_W     = 32;
    localparam int ARG_W     = 34;
    localparam int CX_W      = 38;
    localparam int ANG_W     = 36;
    localparam int RAD_W     = 64;
    localparam int ROOT_W    = 32;
    localparam int WIDE_W    = ANG_W + 2;

    // Output field widths
    localparam int ROLL_W  = 16;
    localparam int PITCH_W = 14;
    localparam int YAW_W   = 15;
    localparam int TDATA_W = 48;

    typedef logic signed [QUAT_WIDTH-1:0] quat_t;
    typedef logic signed [Q30_W-1:0]      q30_t;
    typedef logic signed [ARG_W-1:0]      arg_t;
    typedef logic signed [CX_W-1:0]       cx_t;
    typedef logic signed [ANG_W-1:0]      ang_t;
    typedef logic signed [WIDE_W-1:0]     wide_t;
    typedef logic        [RAD_W-1:0]      rad_t;
    typedef logic        [ROOT_W-1:0]     root_t;

    // Constants in Q.30
    localparam arg_t ONE_ARG     = arg_t'(1 << 30);
    localparam ang_t PI_Q30      = 36'sd3373259426;
    localparam ang_t HALF_PI_Q30 = 36'sd1686629713;

    // Output saturation limits in Q4.12
    localparam wide_t ROLL_LO  = wide_t'(-12868);
    localparam wide_t ROLL_HI  = wide_t'(19302);
    localparam wide_t PITCH_LO = wide_t'(-6434);
    localparam wide_t PITCH_HI = wide_t'(6434);
    localparam wide_t YAW_LO   = wide_t'(-12868);
    localparam wide_t YAW_HI   = wide_t'(12868);

    // Product of two components brought to 30 fraction bits.
    function automatic q30_t mul_q30(input quat_t a, input quat_t b);
        logic signed [PROD_W-1:0] p;
        q30_t r;
        p = PROD_W'(a) * PROD_W'(b);
        if (PROD_FRAC >= 30)
            r = Q30_W'(p >>> (PROD_FRAC - 30));
        else
            r = Q30_W'(p) <<< (30 - PROD_FRAC);
        return r;
    endfunction

    // CORDIC rotation angle atan(2^-i) in Q.30.
    function automatic ang_t stage_angle(input int i);
        ang_t a;
        case (i)
            0:       a = 36'sd843314857;
            1:       a = 36'sd497837829;
            2:       a = 36'sd263043837;
            3:       a = 36'sd133525159;
            4:       a = 36'sd67021687;
            5:       a = 36'sd33543516;
            6:       a = 36'sd16775851;
            7:       a = 36'sd8388437;
            8:       a = 36'sd4194283;
            9:       a = 36'sd2097149;
            default:
            begin
                if (i > 30)
                    a = '0;
                else
                    a = ang_t'(64'sd1 <<< (30 - i));
            end
        endcase
        return a;
    endfunction

    // Round half up from Q.30 to Q4.12 and saturate.
    function automatic wide_t round_sat(input wide_t z, input wide_t lo, input wide_t hi);
        wide_t r;
        r = (z + wide_t'(1 << 17)) >>> 18;
        if (r < lo)
            r = lo;
        else if (r > hi)
            r = hi;
        return r;
    endfunction

endpackage

// File: src/q2e_front.sv
// Front end: component products, sine/cosine terms and the clamped pitch
// argument split into two square root operands. Depends on q2e_pkg.
module q2e_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  q2e_pkg::quat_t    qw,
    input  q2e_pkg::quat_t    qx,
    input  q2e_pkg::quat_t    qy,
    input  q2e_pkg::quat_t    qz,
    output logic              out_valid,
    output q2e_pkg::arg_t     sr,
    output q2e_pkg::arg_t     cr,
    output q2e_pkg::arg_t     sy,
    output q2e_pkg::arg_t     cy,
    output q2e_pkg::rad_t     sqrt_a,
    output q2e_pkg::rad_t     sqrt_b,
    output logic              clamped
);
    import q2e_pkg::*;

    q30_t wx_reg, yz_reg, xx_reg, yy_reg, wy_reg, xz_reg, wz_reg, xy_reg, zz_reg;
    logic v1_reg, v2_reg;
    arg_t sr_reg, cr_reg, sy_reg, cy_reg;
    arg_t sr_next, cr_next, sy_next, cy_next, s_raw, s_sat;
    rad_t sqrt_a_reg, sqrt_b_reg, sqrt_a_next, sqrt_b_next;
    logic clamped_reg, clamped_next;

    // Stage one: the nine component products.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wx_reg <= mul_q30(qw, qx);
            yz_reg <= mul_q30(qy, qz);
            xx_reg <= mul_q30(qx, qx);
            yy_reg <= mul_q30(qy, qy);
            wy_reg <= mul_q30(qw, qy);
            xz_reg <= mul_q30(qx, qz);
            wz_reg <= mul_q30(qw, qz);
            xy_reg <= mul_q30(qx, qy);
            zz_reg <= mul_q30(qz, qz);
        end
    end

    // Stage two: sums, pitch argument clamp and square root operands.
    always_comb
    begin
        sr_next = (arg_t'(wx_reg) + arg_t'(yz_reg)) <<< 1;
        cr_next = ONE_ARG - ((arg_t'(xx_reg) + arg_t'(yy_reg)) <<< 1);
        sy_next = (arg_t'(wz_reg) + arg_t'(xy_reg)) <<< 1;
        cy_next = ONE_ARG - ((arg_t'(yy_reg) + arg_t'(zz_reg)) <<< 1);
        s_raw   = (arg_t'(wy_reg) - arg_t'(xz_reg)) <<< 1;
        clamped_next = 1'b0;
        s_sat = s_raw;
        if (s_raw > ONE_ARG)
        begin
            s_sat = ONE_ARG;
            clamped_next = 1'b1;
        end
        else if (s_raw < -ONE_ARG)
        begin
            s_sat = -ONE_ARG;
            clamped_next = 1'b1;
        end
        sqrt_a_next = rad_t'(ONE_ARG + s_sat) << 30;
        sqrt_b_next = rad_t'(ONE_ARG - s_sat) << 30;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sr_reg      <= sr_next;
            cr_reg      <= cr_next;
            sy_reg      <= sy_next;
            cy_reg      <= cy_next;
            sqrt_a_reg  <= sqrt_a_next;
            sqrt_b_reg  <= sqrt_b_next;
            clamped_reg <= clamped_next;
        end
    end

    // Valid bits of both stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign sr        = sr_reg;
    assign cr        = cr_reg;
    assign sy        = sy_reg;
    assign cy        = cy_reg;
    assign sqrt_a    = sqrt_a_reg;
    assign sqrt_b    = sqrt_b_reg;
    assign clamped   = clamped_reg;

endmodule

// File: src/q2e_isqrt.sv
// Pipelined restoring integer square root, one result bit per stage.
// Depends on q2e_pkg.
module q2e_isqrt (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  q2e_pkg::rad_t     n_in,
    output logic              out_valid,
    output q2e_pkg::root_t    root
);
    import q2e_pkg::*;

    rad_t n_reg   [SQRT_STAGES-1];
    rad_t res_reg [SQRT_STAGES];
    logic v_reg   [SQRT_STAGES];
    rad_t n_cur   [SQRT_STAGES];
    rad_t res_cur [SQRT_STAGES];
    logic v_cur   [SQRT_STAGES];

    genvar k;
    generate
        for (k = 0; k < SQRT_STAGES; k++)
        begin : g_stage
            localparam rad_t BIT = rad_t'(1) << (62 - 2 * k);
            rad_t trial, n_next, res_next;
            logic ge;

            // Stage inputs come from the port or the previous stage.
            if (k == 0)
            begin : g_first
                assign n_cur[k]   = n_in;
                assign res_cur[k] = '0;
                assign v_cur[k]   = in_valid;
            end
            else
            begin : g_rest
                assign n_cur[k]   = n_reg[k-1];
                assign res_cur[k] = res_reg[k-1];
                assign v_cur[k]   = v_reg[k-1];
            end

            // One trial subtraction.
            always_comb
            begin
                trial    = res_cur[k] + BIT;
                ge       = (n_cur[k] >= trial);
                n_next   = ge ? (n_cur[k] - trial) : n_cur[k];
                res_next = ge ? ((res_cur[k] >> 1) + BIT) : (res_cur[k] >> 1);
            end

            always_ff @(posedge clk)
            begin
                if (en)
                    res_reg[k] <= res_next;
            end

            // The remainder is not needed after the last stage.
            if (k < SQRT_STAGES - 1)
            begin : g_keep_n
                always_ff @(posedge clk)
                begin
                    if (en)
                        n_reg[k] <= n_next;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[k] <= 1'b0;
                else if (en)
                    v_reg[k] <= v_cur[k];
            end
        end
    endgenerate

    assign out_valid = v_reg[SQRT_STAGES-1];
    assign root      = res_reg[SQRT_STAGES-1][ROOT_W-1:0];

endmodule

// File: src/q2e_cordic.sv
// Pipelined vectoring CORDIC giving atan2(y, x) in Q.30 radians: a quadrant
// stage followed by one register stage per rotation. Depends on q2e_pkg.
module q2e_cordic (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  q2e_pkg::arg_t     y_in,
    input  q2e_pkg::arg_t     x_in,
    output logic              out_valid,
    output q2e_pkg::ang_t     angle
);
    import q2e_pkg::*;

    cx_t  x_reg    [CORDIC_STAGES];
    cx_t  y_reg    [CORDIC_STAGES];
    ang_t z_reg    [CORDIC_STAGES+1];
    logic zero_reg [CORDIC_STAGES+1];
    logic v_reg    [CORDIC_STAGES+1];
    cx_t  x0_next, y0_next;
    ang_t z0_next;

    // Quadrant stage: fold the left half plane onto the right.
    always_comb
    begin
        if (x_in < 0)
        begin
            x0_next = -cx_t'(x_in);
            y0_next = -cx_t'(y_in);
            z0_next = (y_in >= 0) ? PI_Q30 : -PI_Q30;
        end
        else
        begin
            x0_next = cx_t'(x_in);
            y0_next = cx_t'(y_in);
            z0_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= x0_next;
            y_reg[0]    <= y0_next;
            z_reg[0]    <= z0_next;
            zero_reg[0] <= (x_in == 0) && (y_in == 0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (en)
            v_reg[0] <= in_valid;
    end

    genvar i;
    generate
        for (i = 0; i < CORDIC_STAGES; i++)
        begin : g_stage
            localparam ang_t ANG = stage_angle(i);
            cx_t  xs, ys, x_next, y_next;
            ang_t z_next;

            // Rotate toward the x axis by atan(2^-i).
            always_comb
            begin
                xs = x_reg[i] >>> i;
                ys = y_reg[i] >>> i;
                if (y_reg[i] >= 0)
                begin
                    x_next = x_reg[i] + ys;
                    y_next = y_reg[i] - xs;
                    z_next = z_reg[i] + ANG;
                end
                else
                begin
                    x_next = x_reg[i] - ys;
                    y_next = y_reg[i] + xs;
                    z_next = z_reg[i] - ANG;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    z_reg[i+1]    <= z_next;
                    zero_reg[i+1] <= zero_reg[i];
                end
            end

            // The vector itself is not needed after the last rotation.
            if (i < CORDIC_STAGES - 1)
            begin : g_keep_xy
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        x_reg[i+1] <= x_next;
                        y_reg[i+1] <= y_next;
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[i+1] <= 1'b0;
                else if (en)
                    v_reg[i+1] <= v_reg[i];
            end
        end
    endgenerate

    assign out_valid = v_reg[CORDIC_STAGES];
    assign angle     = zero_reg[CORDIC_STAGES] ? '0 : z_reg[CORDIC_STAGES];

endmodule

// File: src/q2e_back.sv
// Back end: roll clamp and offset, pitch doubling less half pi, rounding to Q4.12
// and saturation, in one register stage. Depends on q2e_pkg.
module q2e_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  q2e_pkg::ang_t                        roll_z,
    input  q2e_pkg::ang_t                        pitch_z,
    input  q2e_pkg::ang_t                        yaw_z,
    input  logic                                 clamped_in,
    input  logic                                 offset_en,
    output logic                                 out_valid,
    output logic signed [q2e_pkg::ROLL_W-1:0]    roll,
    output logic signed [q2e_pkg::PITCH_W-1:0]   pitch,
    output logic signed [q2e_pkg::YAW_W-1:0]     yaw,
    output logic                                 clamped
);
    import q2e_pkg::*;

    ang_t  roll_c;
    wide_t roll_w, pitch_w, yaw_w;
    logic signed [ROLL_W-1:0]  roll_reg;
    logic signed [PITCH_W-1:0] pitch_reg;
    logic signed [YAW_W-1:0]   yaw_reg;
    logic clamped_reg, v_reg;

    // Final angle arithmetic.
    always_comb
    begin
        roll_c = roll_z;
        if (roll_z > PI_Q30)
            roll_c = PI_Q30;
        else if (roll_z < -PI_Q30)
            roll_c = -PI_Q30;
        roll_w = wide_t'(roll_c);
        if (offset_en)
            roll_w = roll_w + wide_t'(HALF_PI_Q30);
        pitch_w = (wide_t'(pitch_z) <<< 1) - wide_t'(HALF_PI_Q30);
        yaw_w   = wide_t'(yaw_z);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            roll_reg    <= ROLL_W'(round_sat(roll_w, ROLL_LO, ROLL_HI));
            pitch_reg   <= PITCH_W'(round_sat(pitch_w, PITCH_LO, PITCH_HI));
            yaw_reg     <= YAW_W'(round_sat(yaw_w, YAW_LO, YAW_HI));
            clamped_reg <= clamped_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= in_valid;
    end

    assign out_valid = v_reg;
    assign roll      = roll_reg;
    assign pitch     = pitch_reg;
    assign yaw       = yaw_reg;
    assign clamped   = clamped_reg;

endmodule

// File: src/quaternion_to_euler_angles_unit.sv
// Quaternion to roll, pitch and yaw converter. One quaternion request is taken
// per cycle while the skid entry is free. The pipeline is the chain of the two
// front-end stages, the 32-stage square root, the 17-stage CORDIC, the rounding
// stage and the output register. A two-entry output buffer lets the pipeline
// keep accepting while one result waits. Depends on q2e_pkg and the q2e_*
// submodules.
module quaternion_to_euler_angles_unit (
    input  logic        clk,
    input  logic        rst_n,
    // Quaternion input: qw [15:0], qx [31:16], qy [47:32], qz [63:48].
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,
    // Angles: roll_angle [15:0], pitch_angle [29:16], yaw_angle [44:30], zero pad.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [q2e_pkg::TDATA_W-1:0] m_tdata,
    // Flags: pitch_clamped [0].
    output logic        m_tuser,
    // Roll offset enable register.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);
    import q2e_pkg::*;

    localparam int FLAG_DELAY = SQRT_STAGES + CORDIC_STAGES + 1;

    logic en;
    logic offset_reg;
    logic f_valid, f_clamped;
    arg_t f_sr, f_cr, f_sy, f_cy;
    rad_t f_sqrt_a, f_sqrt_b;
    logic sq_valid;
    root_t root_a, root_b;
    logic p_valid;
    ang_t roll_z, pitch_z, yaw_z;
    ang_t roll_dly_reg [SQRT_STAGES];
    ang_t yaw_dly_reg  [SQRT_STAGES];
    logic flag_dly_reg [FLAG_DELAY];
    logic b_valid, b_clamped;
    logic signed [ROLL_W-1:0]  b_roll;
    logic signed [PITCH_W-1:0] b_pitch;
    logic signed [YAW_W-1:0]   b_yaw;
    logic [TDATA_W-1:0] b_data;
    logic [TDATA_W-1:0] out_data_reg, skid_data_reg;
    logic out_user_reg, skid_user_reg;
    logic out_v_reg, skid_v_reg;

    // The pipeline moves whenever the skid entry is free.
    assign en       = !skid_v_reg;
    assign s_tready = en;

    // Configuration register.
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            offset_reg <= 1'b1;
        else if (cfg_valid)
            offset_reg <= cfg_data;
    end

    q2e_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .qw        (quat_t'(s_tdata[15:0])),
        .qx        (quat_t'(s_tdata[31:16])),
        .qy        (quat_t'(s_tdata[47:32])),
        .qz        (quat_t'(s_tdata[63:48])),
        .out_valid (f_valid),
        .sr        (f_sr),
        .cr        (f_cr),
        .sy        (f_sy),
        .cy        (f_cy),
        .sqrt_a    (f_sqrt_a),
        .sqrt_b    (f_sqrt_b),
        .clamped   (f_clamped)
    );

    q2e_isqrt u_sqrt_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .n_in      (f_sqrt_a),
        .out_valid (sq_valid),
        .root      (root_a)
    );

    q2e_isqrt u_sqrt_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .n_in      (f_sqrt_b),
        .out_valid (),
        .root      (root_b)
    );

    q2e_cordic u_cordic_roll (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .y_in      (f_sr),
        .x_in      (f_cr),
        .out_valid (),
        .angle     (roll_z)
    );

    q2e_cordic u_cordic_yaw (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .y_in      (f_sy),
        .x_in      (f_cy),
        .out_valid (),
        .angle     (yaw_z)
    );

    q2e_cordic u_cordic_pitch (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .y_in      (arg_t'(root_a)),
        .x_in      (arg_t'(root_b)),
        .out_valid (p_valid),
        .angle     (pitch_z)
    );

    // Delay roll, yaw and the clamp flag to line up with the pitch path.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            roll_dly_reg[0] <= roll_z;
            yaw_dly_reg[0]  <= yaw_z;
            flag_dly_reg[0] <= f_clamped;
            for (int k = 1; k < SQRT_STAGES; k++)
            begin
                roll_dly_reg[k] <= roll_dly_reg[k-1];
                yaw_dly_reg[k]  <= yaw_dly_reg[k-1];
            end
            for (int k = 1; k < FLAG_DELAY; k++)
                flag_dly_reg[k] <= flag_dly_reg[k-1];
        end
    end

    q2e_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (p_valid),
        .roll_z     (roll_dly_reg[SQRT_STAGES-1]),
        .pitch_z    (pitch_z),
        .yaw_z      (yaw_dly_reg[SQRT_STAGES-1]),
        .clamped_in (flag_dly_reg[FLAG_DELAY-1]),
        .offset_en  (offset_reg),
        .out_valid  (b_valid),
        .roll       (b_roll),
        .pitch      (b_pitch),
        .yaw        (b_yaw),
        .clamped    (b_clamped)
    );

    assign b_data = TDATA_W'({b_yaw, b_pitch, b_roll});

    // Output register with one skid entry.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (skid_v_reg)
        begin
            if (m_tready)
            begin
                out_data_reg <= skid_data_reg;
                out_user_reg <= skid_user_reg;
                skid_v_reg   <= 1'b0;
            end
        end
        else if (b_valid)
        begin
            if (!out_v_reg || m_tready)
            begin
                out_data_reg <= b_data;
                out_user_reg <= b_clamped;
                out_v_reg    <= 1'b1;
            end
            else
            begin
                skid_data_reg <= b_data;
                skid_user_reg <= b_clamped;
                skid_v_reg    <= 1'b1;
            end
        end
        else if (m_tready)
        begin
            out_v_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // The skid entry is only occupied behind a held output.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> out_v_reg)
        else $error("skid entry valid while output register empty");

    // The skid entry fills only when the output was stalled.
    a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_v_reg) |-> $past(out_v_reg && !m_tready))
        else $error("skid entry filled without an output stall");

    // The skid entry holds its data while the output is stalled.
    a_hold_on_full: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg && !m_tready |=> skid_v_reg && $stable(skid_data_reg))
        else $error("skid entry changed while output stalled");

endmodule

// File: sim/tb_quaternion_to_euler_angles_unit.sv
// Self-checking testbench of the quaternion to Euler angle converter.
// Depends on q2e_pkg and quaternion_to_euler_angles_unit; drives directed and random traffic.
module tb_quaternion_to_euler_angles_unit;
    import q2e_pkg::*;

    localparam int LATENCY    = 53;
    localparam int WATCHDOG   = 20000;
    localparam int RAND_ITEMS = 1650;
    localparam int N_DIRECTED = 16;
    localparam logic [63:0] PI_ANG   = 64'sd3373259426;
    localparam logic [63:0] HALF_ANG = 64'sd1686629713;
    localparam logic [63:0] ONE_ANG  = 64'sd1073741824;

    typedef struct packed {
        logic        clamped;
        logic [14:0] yaw;
        logic [13:0] pitch;
        logic [15:0] roll;
    } angles_t;

    typedef struct {
        logic [15:0] w, x, y, z;
        logic        known;   // expected result typed in
        angles_t     ang;
    } quat_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [TDATA_W-1:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_data;

    quaternion_to_euler_angles_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    angles_t   angle_queue[$];
    quat_row_t quat_table[N_DIRECTED];
    logic      offset_on;
    int        mismatches;
    int        idle_cycles;
    bit        timed_out;

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Arithmetic shift right on 64-bit signed values.
    function automatic logic signed [63:0] shr(input logic signed [63:0] v, input int s);
        return v >>> s;
    endfunction

    // Product of two Q1.15 components in Q.30.
    function automatic logic signed [63:0] prod30(input logic signed [15:0] a,
                                                  input logic signed [15:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        return p;
    endfunction

    // Vectoring CORDIC atan2 in Q.30 radians.
    function automatic logic signed [63:0] vec_atan2(input logic signed [63:0] yi,
                                                     input logic signed [63:0] xi);
        logic signed [63:0] xv, yv, zv, nx, ny, step;
        xv = xi;
        yv = yi;
        zv = 0;
        if (xv == 0 && yv == 0)
            return 0;
        if (xv < 0)
        begin
            zv = (yv >= 0) ? PI_ANG : -PI_ANG;
            xv = -xv;
            yv = -yv;
        end
        for (int i = 0; i < CORDIC_STAGES; i++)
        begin
            case (i)
                0: step = 843314857;
                1: step = 497837829;
                2: step = 263043837;
                3: step = 133525159;
                4: step = 67021687;
                5: step = 33543516;
                6: step = 16775851;
                7: step = 8388437;
                8: step = 4194283;
                9: step = 2097149;
                default: step = (i > 30) ? 64'sd0 : (64'sd1 <<< (30 - i));
            endcase
            if (yv >= 0)
            begin
                nx = xv + shr(yv, i);
                ny = yv - shr(xv, i);
                zv = zv + step;
            end
            else
            begin
                nx = xv - shr(yv, i);
                ny = yv + shr(xv, i);
                zv = zv - step;
            end
            xv = nx;
            yv = ny;
        end
        return zv;
    endfunction

    // Floor integer square root of a 64-bit value.
    function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
        logic [63:0] rem, root, bitv;
        rem = n;
        root = 0;
        bitv = 64'd1 << 62;
        for (int k = 0; k < 32; k++)
        begin
            if (rem >= root + bitv)
            begin
                rem = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Round Q.30 to Q4.12 half up and saturate.
    function automatic logic signed [63:0] to_q412(input logic signed [63:0] v,
                                                   input logic signed [63:0] lo,
                                                   input logic signed [63:0] hi);
        logic signed [63:0] r;
        r = (v + 64'sd131072) >>> 18;
        if (r < lo)
            r = lo;
        if (r > hi)
            r = hi;
        return r;
    endfunction

    // Expected angles of one quaternion under the current offset setting.
    function automatic angles_t euler_angles(input logic signed [15:0] w,
                                             input logic signed [15:0] x,
                                             input logic signed [15:0] y,
                                             input logic signed [15:0] z);
        logic signed [63:0] sr, cr, sy, cy, sp, ra, rb, roll, pitch, yaw;
        angles_t res;
        res.clamped = 1'b0;
        sr = 2 * (prod30(w, x) + prod30(y, z));
        cr = ONE_ANG - 2 * (prod30(x, x) + prod30(y, y));
        roll = vec_atan2(sr, cr);
        if (roll > $signed(PI_ANG))
            roll = PI_ANG;
        if (roll < -$signed(PI_ANG))
            roll = -PI_ANG;
        if (offset_on)
            roll = roll + HALF_ANG;
        sp = 2 * (prod30(w, y) - prod30(x, z));
        if (sp > $signed(ONE_ANG))
        begin
            sp = ONE_ANG;
            res.clamped = 1'b1;
        end
        if (sp < -$signed(ONE_ANG))
        begin
            sp = -ONE_ANG;
            res.clamped = 1'b1;
        end
        ra = floor_sqrt((ONE_ANG + sp) << 30);
        rb = floor_sqrt((ONE_ANG - sp) << 30);
        pitch = 2 * vec_atan2(ra, rb) - HALF_ANG;
        sy = 2 * (prod30(w, z) + prod30(x, y));
        cy = ONE_ANG - 2 * (prod30(y, y) + prod30(z, z));
        yaw = vec_atan2(sy, cy);
        res.roll  = 16'(to_q412(roll, -12868, 19302));
        res.pitch = 14'(to_q412(pitch, -6434, 6434));
        res.yaw   = 15'(to_q412(yaw, -12868, 12868));
        return res;
    endfunction

    // Directed rows; only the identity row has its result typed in.
    initial
    begin
        quat_table[0]  = '{16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 1'b1,
                           '{1'b0, 15'd0, 14'd0, 16'd6434}};
        quat_table[1]  = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, '0};
        quat_table[2]  = '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0, '0};
        quat_table[3]  = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, '0};
        quat_table[4]  = '{16'h7FFF, 16'h0000, 16'h7FFF, 16'h0000, 1'b0, '0};
        quat_table[5]  = '{16'h7FFF, 16'h0000, 16'h8000, 16'h0000, 1'b0, '0};
        quat_table[6]  = '{16'h0000, 16'h7FFF, 16'h0000, 16'h0000, 1'b0, '0};
        quat_table[7]  = '{16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 1'b0, '0};
        quat_table[8]  = '{16'h5A82, 16'h5A82, 16'h0000, 16'h0000, 1'b0, '0};
        quat_table[9]  = '{16'h5A82, 16'h0000, 16'h5A82, 16'h0000, 1'b0, '0};
        quat_table[10] = '{16'h5A82, 16'h0000, 16'h0000, 16'hA57E, 1'b0, '0};
        quat_table[11] = '{16'h4000, 16'h4000, 16'h4000, 16'h4000, 1'b0, '0};
        quat_table[12] = '{16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 1'b0, '0};
        quat_table[13] = '{16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF, 1'b0, '0};
        quat_table[14] = '{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b0, '0};
        quat_table[15] = '{16'h0000, 16'h8000, 16'h0000, 16'h0000, 1'b0, '0};
    end

    // Receiver stalls on a slowly changing random pattern.
    initial
    begin
        int mode;
        int span;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(1, 40);
            repeat (span)
            begin
                @(posedge clk);
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 3) != 0);
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= 1'b0;
                endcase
            end
        end
    end

    // Result check and watchdog.
    always @(posedge clk)
    begin
        angles_t got;
        angles_t want;
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (cfg_valid && cfg_ready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (m_tvalid && m_tready)
            begin
                got.roll    = m_tdata[15:0];
                got.pitch   = m_tdata[29:16];
                got.yaw     = m_tdata[44:30];
                got.clamped = m_tuser;
                if (angle_queue.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("unexpected result %h", got);
                end
                else
                begin
                    want = angle_queue.pop_front();
                    if (got !== want)
                    begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                            $display("mismatch: roll %0d/%0d pitch %0d/%0d yaw %0d/%0d flag %b/%b",
                                     $signed(want.roll), $signed(got.roll),
                                     $signed(want.pitch), $signed(got.pitch),
                                     $signed(want.yaw), $signed(got.yaw),
                                     want.clamped, got.clamped);
                    end
                end
            end
            if (idle_cycles >= WATCHDOG)
                timed_out = 1'b1;
        end
    end

    // Send one request and queue its expected angles at acceptance.
    task automatic send_quat(input logic [15:0] w, input logic [15:0] x,
                             input logic [15:0] y, input logic [15:0] z,
                             input bit known, input angles_t typed);
        angles_t pred;
        pred = euler_angles(w, x, y, z);
        s_tvalid <= 1'b1;
        s_tdata  <= {z, y, x, w};
        do
            @(posedge clk);
        while (!s_tready);
        if (known && typed !== pred)
        begin
            mismatches = mismatches + 1;
            $display("predictor disagrees with table row %h", typed);
        end
        angle_queue.push_back(pred);
    endtask

    // Wait for all results, drain the pipeline, then write the register.
    task automatic set_offset(input logic value);
        s_tvalid <= 1'b0;
        while (angle_queue.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        offset_on = value;
    endtask

    // Random quaternion component, biased toward extremes, zero and small values.
    function automatic logic [15:0] rand_comp();
        case ($urandom_range(0, 7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'($urandom_range(0, 64) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    // Random quaternion from biased components, most often halved.
    task automatic send_random();
        logic [15:0] c[4];
        int k;
        for (k = 0; k < 4; k++)
            c[k] = rand_comp();
        if ($urandom_range(0, 2) != 0)
            for (k = 0; k < 4; k++)
                c[k] = 16'($signed(c[k]) >>> 1);
        // Send with no typed result; the caller makes the gap between bursts.
        send_quat(c[0], c[1], c[2], c[3], 1'b0, '0);
    endtask

    // Main stimulus.
    initial
    begin
        int burst;
        int sent;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_data = 1'b0;
        rst_n = 1'b0;
        offset_on = 1'b1;
        mismatches = 0;
        idle_cycles = 0;
        timed_out = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table with the reset offset, then all rows but the first with the offset cleared.
        for (int r = 0; r < N_DIRECTED; r++)
            send_quat(quat_table[r].w, quat_table[r].x, quat_table[r].y,
                      quat_table[r].z, quat_table[r].known, quat_table[r].ang);
        set_offset(1'b0);
        for (int r = 1; r < N_DIRECTED; r++)
            send_quat(quat_table[r].w, quat_table[r].x, quat_table[r].y,
                      quat_table[r].z, 1'b0, '0);

        // Random phases across both register settings.
        sent = 0;
        for (int phase = 0; phase < 4; phase++)
        begin
            set_offset(phase[0]);
            while (sent < (phase + 1) * RAND_ITEMS / 4)
            begin
                burst = $urandom_range(1, 30);
                repeat (burst)
                begin
                    send_random();
                    sent++;
                end
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
        s_tvalid <= 1'b0;

        // Drain.
        while (angle_queue.size() != 0 && !timed_out)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
        if (timed_out || mismatches != 0 || angle_queue.size() != 0)
            $display("FAILURE");
        else
            $display("SUCCESS");
        $finish;
    end

    // Timeout exit.
    initial
    begin
        wait (timed_out);
        $display("FAILURE");
        $finish;
    end

endmodule

// File: filelist.f
src/q2e_pkg.sv
src/q2e_front.sv
src/q2e_isqrt.sv
src/q2e_cordic.sv
src/q2e_back.sv
src/quaternion_to_euler_angles_unit.sv
sim/tb_quaternion_to_euler_angles_unit.sv
